FILE: design/hexp_pkg.sv
// Shared types and character constants for the hex text parser.
// Used by the classifier, the parse core and the top level.
`default_nettype none

package hexp_pkg;

  localparam int ValueWidth = 64;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  localparam logic [3:0] LETTER_BIAS = 4'd9;

  typedef enum logic [5:0] {
    PH_SPACE  = 6'b000001,
    PH_SIGNED = 6'b000010,
    PH_ZERO   = 6'b000100,
    PH_PREFIX = 6'b001000,
    PH_DIGITS = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       is_space;
    logic       is_sign;
    logic       is_minus;
    logic       is_zero;
    logic       is_x;
    logic       is_hex;
    logic [3:0] digit;
  } char_class_t;

  typedef struct packed {
    logic [ValueWidth-1:0] parsed_value;
    logic                  has_digits;
    logic                  overflowed;
    logic                  valid_res;
  } result_t;

endpackage

`default_nettype wire

FILE: design/hex_text_to_u64_parser.sv
// Hex text parser, top level: input word register, classifier, parse core,
// result register. A terminator word passes from the input word register to
// the result register. Throughput: one word per cycle; a terminator stalls
// only while the previous result is still held. Reset (rst, synchronous)
// empties both registers and returns the parse state to leading whitespace.
// Depends on hexp_pkg, hexp_class and hexp_core.
`default_nettype none

module hex_text_to_u64_parser
  import hexp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [7:0]            char_code,
  input  wire logic                  end_of_text,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [ValueWidth-1:0] parsed_value,
  output      logic                  has_digits,
  output      logic                  overflowed,
  output      logic                  valid_res
);

  logic        held;
  logic [7:0]  char_q;
  logic        eot_q;
  logic        proceed;
  char_class_t cls;
  result_t     res;

  // a terminator word waits only for room in the result register
  assign proceed  = held && (!eot_q || !out_valid || out_ready);
  assign in_ready = !held || proceed;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      char_q <= char_code;
      eot_q  <= end_of_text;
    end
  end

  hexp_class u_class (
    .char_code (char_q),
    .cls       (cls)
  );

  hexp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (proceed),
    .end_of_text (eot_q),
    .cls         (cls),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proceed && eot_q) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && eot_q) begin
      parsed_value <= res.parsed_value;
      has_digits   <= res.has_digits;
      overflowed   <= res.overflowed;
      valid_res    <= res.valid_res;
    end
  end

endmodule

`default_nettype wire

FILE: design/hexp_class.sv
// Character classifier: whitespace, sign, prefix and hex digit decode.
// Depends on hexp_pkg.
`default_nettype none

module hexp_class
  import hexp_pkg::*;
(
  input  wire logic [7:0] char_code,
  output char_class_t     cls
);

  logic is_dec;
  logic is_upper;
  logic is_lower;

  always_comb begin
    is_dec   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    is_upper = (char_code >= CH_UA) && (char_code <= CH_UF);
    is_lower = (char_code >= CH_LA) && (char_code <= CH_LF_HEX);

    cls.is_space = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
                   (char_code == CH_LF) || (char_code == CH_VT) ||
                   (char_code == CH_FF) || (char_code == CH_CR);
    cls.is_minus = (char_code == CH_MINUS);
    cls.is_sign  = cls.is_minus || (char_code == CH_PLUS);
    cls.is_zero  = (char_code == CH_ZERO);
    cls.is_x     = (char_code == CH_LX) || (char_code == CH_UX);
    cls.is_hex   = is_dec || is_upper || is_lower;
    // letters sit at low nibble 1..6, so add nine for 10..15
    cls.digit    = is_dec ? char_code[3:0] : (char_code[3:0] + LETTER_BIAS);
  end

endmodule

`default_nettype wire

FILE: design/hexp_core.sv
// Parse state: phase machine, sign, accumulator and flags; forms the result.
// Depends on hexp_pkg.
`default_nettype none

module hexp_core
  import hexp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic        end_of_text,
  input  char_class_t      cls,
  output result_t          res
);

  phase_t                phase, phase_next;
  logic                  minus_seen, minus_seen_next;
  logic [ValueWidth-1:0] accumulator, accumulator_next;
  logic                  digit_seen, digit_seen_next;
  logic                  overflow_seen, overflow_seen_next;

  logic                  take;
  logic [ValueWidth-1:0] acc_shift;
  logic                  acc_top;

  assign acc_shift = {accumulator[ValueWidth-5:0], cls.digit};
  assign acc_top   = |accumulator[ValueWidth-1:ValueWidth-4];

  always_comb begin
    phase_next         = phase;
    minus_seen_next    = minus_seen;
    digit_seen_next    = digit_seen;
    take               = 1'b0;

    unique case (phase)
      PH_SPACE, PH_SIGNED: begin
        if (phase == PH_SPACE && cls.is_space) begin
          phase_next = PH_SPACE;
        end else if (phase == PH_SPACE && cls.is_sign) begin
          minus_seen_next = cls.is_minus;
          phase_next      = PH_SIGNED;
        end else if (cls.is_zero) begin
          // the zero counts unless an x follows
          digit_seen_next = 1'b1;
          phase_next      = PH_ZERO;
        end else if (cls.is_hex) begin
          take       = 1'b1;
          phase_next = PH_DIGITS;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_ZERO: begin
        if (cls.is_x) begin
          digit_seen_next = 1'b0;
          phase_next      = PH_PREFIX;
        end else if (cls.is_hex) begin
          take       = 1'b1;
          phase_next = PH_DIGITS;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_PREFIX, PH_DIGITS: begin
        if (cls.is_hex) begin
          take       = 1'b1;
          phase_next = PH_DIGITS;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase

    accumulator_next   = take ? acc_shift : accumulator;
    overflow_seen_next = overflow_seen || (take && acc_top);
    if (take) begin
      digit_seen_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_text)) begin
      phase         <= PH_SPACE;
      minus_seen    <= 1'b0;
      accumulator   <= '0;
      digit_seen    <= 1'b0;
      overflow_seen <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      minus_seen    <= minus_seen_next;
      accumulator   <= accumulator_next;
      digit_seen    <= digit_seen_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  always_comb begin
    if (overflow_seen) begin
      res.parsed_value = '1;
    end else if (minus_seen) begin
      res.parsed_value = '0 - accumulator;
    end else begin
      res.parsed_value = accumulator;
    end
    res.has_digits = digit_seen;
    res.overflowed = overflow_seen;
    res.valid_res  = digit_seen && !overflow_seen;
  end

endmodule

`default_nettype wire

FILE: design/hexp_checker.sv
// Port-level checks for the hex text parser and the bind that attaches them.
// Depends on hex_text_to_u64_parser.
`default_nettype none

module hexp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [7:0]  char_code,
  input wire logic        end_of_text,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] parsed_value,
  input wire logic        has_digits,
  input wire logic        overflowed,
  input wire logic        valid_res
);

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result word present right after reset");

  a_valid_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (valid_res == (has_digits && !overflowed)))
    else $error("valid_res disagrees with digit and overflow flags");

  a_overflow_ones: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflowed) |-> (has_digits && (parsed_value == '1)))
    else $error("overflow result is not saturated");

  a_no_digits_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_digits) |-> ((parsed_value == '0) && !overflowed))
    else $error("result without digits is not zero");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(parsed_value)))
    else $error("stalled result word changed");

endmodule

bind hex_text_to_u64_parser hexp_checker u_hexp_checker (.*);

`default_nettype wire

FILE: tb/hex_text_to_u64_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for hex_text_to_u64_parser: drives character words,
// predicts each terminator's result and checks it at the output handshake.
// Depends on hexp_pkg for the character constants, phase codes and result type.

module hex_text_to_u64_parser_tb;
  import hexp_pkg::*;

  localparam int CYCLE_LIMIT    = 200_000;
  localparam int RX_HOLD_CYCLES = 100;
  localparam int DIRECTED_ROWS  = 25;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
    bit         fixed;
    result_t    want;
  } stim_row_t;

  localparam result_t EMPTY_TEXT = '{64'd0, 1'b0, 1'b0, 1'b0};
  localparam result_t LONE_ZERO  = '{64'd0, 1'b1, 1'b0, 1'b1};
  localparam result_t MINUS_ONE  = '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b1};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            char_code = 8'h00;
  logic                  end_of_text = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ValueWidth-1:0] parsed_value;
  logic                  has_digits;
  logic                  overflowed;
  logic                  valid_res;

  hex_text_to_u64_parser uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .end_of_text  (end_of_text),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .parsed_value (parsed_value),
    .has_digits   (has_digits),
    .overflowed   (overflowed),
    .valid_res    (valid_res)
  );

  // parse state of the predictor
  phase_t                parse_phase;
  bit                    parse_minus;
  logic [ValueWidth-1:0] parse_acc;
  bit                    parse_digits;
  bit                    parse_ovf;

  result_t   pending_results[$];
  stim_row_t directed_rows[DIRECTED_ROWS];
  logic [7:0] blanks[6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

  int  words_sent = 0;
  int  texts_closed = 0;
  int  results_checked = 0;
  int  ovf_results = 0;
  int  fail_count = 0;
  int  cycle_count = 0;
  int  hold_req = 0;
  int  hold_taken = 0;
  bit  tx_gaps = 1'b0;
  bit  calm_tail = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void clear_parse();
    parse_phase  = PH_SPACE;
    parse_minus  = 1'b0;
    parse_acc    = '0;
    parse_digits = 1'b0;
    parse_ovf    = 1'b0;
  endfunction

  function automatic void shift_in_nibble(input int d);
    if (parse_acc > {4'h0, {(ValueWidth-4){1'b1}}}) parse_ovf = 1'b1;
    parse_acc    = {parse_acc[ValueWidth-5:0], 4'(d)};
    parse_digits = 1'b1;
  endfunction

  // Advance the parse by one word; a terminator yields the result and clears.
  function automatic void parse_char(input logic [7:0] c, input logic eot,
                                     output bit emit, output result_t r);
    int d;
    bit blank;
    bit sign;
    emit = 1'b0;
    r    = '0;
    if (eot) begin
      emit           = 1'b1;
      r.parsed_value = parse_ovf ? '1 : (parse_minus ? ('0 - parse_acc) : parse_acc);
      r.has_digits   = parse_digits;
      r.overflowed   = parse_ovf;
      r.valid_res    = parse_digits && !parse_ovf;
      clear_parse();
      return;
    end
    d = -1;
    if (c >= CH_ZERO && c <= CH_NINE) d = int'(c - CH_ZERO);
    else if (c >= CH_LA && c <= CH_LF_HEX) d = int'(c - CH_LA) + 10;
    else if (c >= CH_UA && c <= CH_UF) d = int'(c - CH_UA) + 10;
    blank = c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    sign  = (c == CH_PLUS) || (c == CH_MINUS);
    // first character past the whitespace that is not a sign: handle as after a sign
    if (parse_phase == PH_SPACE && !blank && !sign) parse_phase = PH_SIGNED;
    case (parse_phase)
      PH_SPACE: begin
        if (sign) begin
          parse_minus = (c == CH_MINUS);
          parse_phase = PH_SIGNED;
        end
      end
      PH_SIGNED: begin
        if (c == CH_ZERO) begin
          parse_digits = 1'b1;
          parse_phase  = PH_ZERO;
        end else if (d >= 0) begin
          shift_in_nibble(d);
          parse_phase = PH_DIGITS;
        end else begin
          parse_phase = PH_DONE;
        end
      end
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          parse_digits = 1'b0;
          parse_phase  = PH_PREFIX;
        end else if (d >= 0) begin
          shift_in_nibble(d);
          parse_phase = PH_DIGITS;
        end else begin
          parse_phase = PH_DONE;
        end
      end
      PH_PREFIX, PH_DIGITS: begin
        if (d >= 0) begin
          shift_in_nibble(d);
          parse_phase = PH_DIGITS;
        end else begin
          parse_phase = PH_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one word, hold it until accepted, then log what it should produce.
  task automatic send_word(input logic [7:0] ch, input logic eot,
                           input bit fixed, input result_t want);
    bit      emit;
    result_t got;
    in_valid    <= 1'b1;
    char_code   <= ch;
    end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    parse_char(ch, eot, emit, got);
    if (emit) begin
      pending_results.push_back(fixed ? want : got);
      texts_closed++;
    end
    words_sent++;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] hex_char(input int nib, input bit upper);
    if (nib < 10) return CH_ZERO + 8'(nib);
    return (upper ? CH_UA : CH_LA) + 8'(nib - 10);
  endfunction

  // One text closed by a terminator: mostly well formed, sometimes pure noise.
  task automatic send_text();
    int n_dig;
    int n_lead;
    int style;
    int nib;
    tx_gaps = !calm_tail && ($urandom_range(0, 2) != 0);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, 6)) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
    end else begin
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) send_word(blanks[$urandom_range(0, 5)], 1'b0, 1'b0, '0);
      case ($urandom_range(0, 3))
        0: send_word(CH_PLUS, 1'b0, 1'b0, '0);
        1: send_word(CH_MINUS, 1'b0, 1'b0, '0);
        default: ;
      endcase
      case ($urandom_range(0, 3))
        0: begin
          send_word(CH_ZERO, 1'b0, 1'b0, '0);
          send_word(CH_LX, 1'b0, 1'b0, '0);
        end
        1: begin
          send_word(CH_ZERO, 1'b0, 1'b0, '0);
          send_word(CH_UX, 1'b0, 1'b0, '0);
        end
        2: send_word(CH_ZERO, 1'b0, 1'b0, '0);
        default: ;
      endcase
      n_dig = $urandom_range(0, 19);
      if (n_dig < 2) n_dig = 0;
      else if (n_dig < 14) n_dig = $urandom_range(1, 16);
      else if (n_dig < 17) n_dig = 16;
      else n_dig = $urandom_range(17, 24);
      style  = $urandom_range(0, 3);
      n_lead = (style == 1) ? $urandom_range(1, 8) : 0;
      for (int i = 0; i < n_dig; i++) begin
        if (style == 0) nib = 15;
        else if (i < n_lead) nib = 0;
        else nib = $urandom_range(0, 15);
        send_word(hex_char(nib, 1'($urandom_range(0, 1))), 1'b0, 1'b0, '0);
      end
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
    end
    send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
  endtask

  function automatic bit field_ok(input string name, input logic [63:0] want,
                                  input logic [63:0] got);
    if (got === want) return 1'b1;
    $display("%0t: %s expected %h actual %h", $time, name, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    result_t want;
    bit      ok;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, parsed_value);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        ok   = field_ok("parsed_value", want.parsed_value, parsed_value);
        ok   = field_ok("has_digits", want.has_digits, has_digits) && ok;
        ok   = field_ok("overflowed", want.overflowed, overflowed) && ok;
        ok   = field_ok("valid_res", want.valid_res, valid_res) && ok;
        if (!ok) fail_count++;
        if (overflowed) ovf_results++;
        results_checked++;
      end
    end
  end

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      if (hold_req != hold_taken) begin
        hold_taken = hold_req;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    directed_rows = '{
      '{8'h00,     1'b1, 1'b1, EMPTY_TEXT},
      '{CH_ZERO,   1'b0, 1'b0, '0},
      '{8'h00,     1'b1, 1'b1, LONE_ZERO},
      '{CH_ZERO,   1'b0, 1'b0, '0},
      '{CH_UX,     1'b0, 1'b0, '0},
      '{8'hFF,     1'b1, 1'b1, EMPTY_TEXT},
      '{8'hFF,     1'b0, 1'b0, '0},
      '{8'hFF,     1'b1, 1'b1, EMPTY_TEXT},
      '{CH_MINUS,  1'b0, 1'b0, '0},
      '{8'h31,     1'b0, 1'b0, '0},
      '{8'h00,     1'b1, 1'b1, MINUS_ONE},
      '{CH_CR,     1'b0, 1'b0, '0},
      '{CH_PLUS,   1'b0, 1'b0, '0},
      '{CH_ZERO,   1'b0, 1'b0, '0},
      '{CH_ZERO,   1'b0, 1'b0, '0},
      '{CH_LA,     1'b0, 1'b0, '0},
      '{CH_MINUS,  1'b0, 1'b0, '0},
      '{8'h37,     1'b0, 1'b0, '0},
      '{8'h5A,     1'b1, 1'b0, '0},
      '{CH_LF,     1'b0, 1'b0, '0},
      '{CH_ZERO,   1'b0, 1'b0, '0},
      '{CH_LX,     1'b0, 1'b0, '0},
      '{8'h67,     1'b0, 1'b0, '0},
      '{8'h35,     1'b0, 1'b0, '0},
      '{8'hA5,     1'b1, 1'b0, '0}
    };
    clear_parse();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_word(directed_rows[i].ch, directed_rows[i].eot, directed_rows[i].fixed,
                directed_rows[i].want);

    while (words_sent < 700) send_text();

    // back up the output with short texts while the receiver holds off
    tx_gaps = 1'b0;
    hold_req++;
    repeat (40) begin
      send_word(hex_char($urandom_range(0, 15), 1'b1), 1'b0, 1'b0, '0);
      send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
    end

    // drain everything before resuming
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);

    while (words_sent < 1350) send_text();
    calm_tail = 1'b1;
    while (words_sent < 1550) send_text();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d words in %0d texts; %0d results checked, %0d of them overflowed",
             words_sent, texts_closed, results_checked, ovf_results);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatching results", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: hex_text_to_u64_parser.f
design/hexp_pkg.sv
design/hexp_class.sv
design/hexp_core.sv
design/hex_text_to_u64_parser.sv
design/hexp_checker.sv
tb/hex_text_to_u64_parser_tb.sv
